// ===== hdl/jrc_pkg.sv =====
// Shared types, constants and the CRC-32 byte step for the journal record checker.
// No dependencies; taken in by jrc_verdict and journal_record_checker.
package jrc_pkg;

    localparam int unsigned SECTOR_BYTES_DEF  = 512;
    localparam int unsigned NAME_BYTES_DEF    = 32;
    localparam int unsigned CONTENT_BYTES_DEF = 448;

    localparam logic [31:0] MAGIC_WORD   = 32'h314A_5346;
    localparam logic [15:0] VERSION_WORD = 16'h0001;
    localparam logic [31:0] COMMIT_MARK  = 32'hC0DE_17ED;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam int unsigned HDR_BYTES     = 20;
    localparam int unsigned CRC_HDR_BYTES = 16;
    localparam int unsigned COMMIT_BYTES  = 4;

    localparam int unsigned OUT_TDATA_W = 72;

    // operation codes after reset
    localparam logic [15:0] WRITE_OP_RESET  = 16'd1;
    localparam logic [15:0] REMOVE_OP_RESET = 16'd2;

    // configuration register indexes
    localparam logic CFG_WRITE_OP  = 1'b0;
    localparam logic CFG_REMOVE_OP = 1'b1;

    typedef enum logic [3:0] {
        REASON_OK          = 4'd0,
        REASON_MAGIC       = 4'd1,
        REASON_VERSION     = 4'd2,
        REASON_ZERO_SEQ    = 4'd3,
        REASON_COMMIT      = 4'd4,
        REASON_OP          = 4'd5,
        REASON_NAME        = 4'd6,
        REASON_LENGTH      = 4'd7,
        REASON_REMOVE_DATA = 4'd8,
        REASON_CRC         = 4'd9,
        REASON_PADDING     = 4'd10
    } t_reason;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] op;
        logic [31:0] seq;
        logic [15:0] name_len;
        logic [15:0] content_len;
        logic [31:0] commit;
        logic [31:0] crc;
        logic [31:0] stored_crc;
        logic        flag_name;
        logic        flag_pad;
    } t_sector;

    typedef struct packed {
        logic        record_valid;
        t_reason     reason;
        logic [15:0] op;
        logic [31:0] seq;
        logic [4:0]  name_len;
        logic [8:0]  content_len;
    } t_verdict;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ===== hdl/jrc_verdict.sv =====
// Verdict logic: ranks the sector checks and picks the first failing reason.
// Depends on jrc_pkg.
module jrc_verdict
    import jrc_pkg::*;
#(
    parameter int unsigned NAME_BYTES    = NAME_BYTES_DEF,
    parameter int unsigned CONTENT_BYTES = CONTENT_BYTES_DEF
) (
    input  t_sector     i_sector,
    input  logic [15:0] i_write_op,
    input  logic [15:0] i_remove_op,
    output t_verdict    o_verdict
);

    logic    w_name_ok;
    logic    w_len_ok;
    t_reason w_reason;

    assign w_name_ok = (i_sector.name_len != 16'd0) &&
                       (32'(i_sector.name_len) < NAME_BYTES) && !i_sector.flag_name;
    assign w_len_ok  = 32'(i_sector.content_len) <= CONTENT_BYTES;

    always_comb begin
        if (i_sector.magic != MAGIC_WORD) begin
            w_reason = REASON_MAGIC;
        end else if (i_sector.version != VERSION_WORD) begin
            w_reason = REASON_VERSION;
        end else if (i_sector.seq == 32'd0) begin
            w_reason = REASON_ZERO_SEQ;
        end else if (i_sector.commit != COMMIT_MARK) begin
            w_reason = REASON_COMMIT;
        end else if (i_sector.op != i_write_op && i_sector.op != i_remove_op) begin
            w_reason = REASON_OP;
        end else if (!w_name_ok) begin
            w_reason = REASON_NAME;
        end else if (!w_len_ok) begin
            w_reason = REASON_LENGTH;
        end else if (i_sector.op == i_remove_op && i_sector.content_len != 16'd0) begin
            w_reason = REASON_REMOVE_DATA;
        end else if (~i_sector.crc != i_sector.stored_crc) begin
            w_reason = REASON_CRC;
        end else if (i_sector.flag_pad) begin
            w_reason = REASON_PADDING;
        end else begin
            w_reason = REASON_OK;
        end
    end

    always_comb begin
        o_verdict.record_valid = (w_reason == REASON_OK);
        o_verdict.reason       = w_reason;
        o_verdict.op           = i_sector.op;
        o_verdict.seq          = i_sector.seq;
        o_verdict.name_len     = w_name_ok ? i_sector.name_len[4:0] : 5'd0;
        o_verdict.content_len  = w_len_ok ? i_sector.content_len[8:0] : 9'd0;
    end

endmodule

// ===== hdl/journal_record_checker.sv =====
// Top level of the journal record checker: byte stream in, one verdict per sector out.
// Depends on jrc_pkg and jrc_verdict.
//
// Takes one sector byte per clock and gives one verdict request after the last byte of
// every SECTOR_BYTES-byte sector. Bytes pass an input register, then the per-byte checks
// and a byte-wide CRC-32 step update the sector state; on the last byte the verdict is
// formed combinationally and loaded into the output register when that byte leaves the
// input register. Sustained rate is one byte per cycle, set by the combinational CRC
// step; the input stalls only when the last byte of a sector meets a verdict that is
// still waiting to be taken. The position counter and the sector state clear themselves
// after each verdict, so sectors follow each other with no gap. Configuration writes
// belong between sectors, while no byte is in flight.
module journal_record_checker
    import jrc_pkg::*;
#(
    parameter int unsigned SECTOR_BYTES  = SECTOR_BYTES_DEF,
    parameter int unsigned NAME_BYTES    = NAME_BYTES_DEF,
    parameter int unsigned CONTENT_BYTES = CONTENT_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // sector_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // record_valid, fail_reason, operation, sequence_number, name_len, content_len, zeros
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [15:0]            i_cfg_wdata
);

    localparam int unsigned PW            = $clog2(SECTOR_BYTES);
    localparam int unsigned CONTENT_START = HDR_BYTES + NAME_BYTES;
    localparam int unsigned PAYLOAD_END   = CONTENT_START + CONTENT_BYTES;
    localparam int unsigned COMMIT_START  = SECTOR_BYTES - COMMIT_BYTES;
    localparam logic [PW-1:0] POS_LAST    = PW'(SECTOR_BYTES - 1);

    logic [15:0]   r_write_op;
    logic [15:0]   r_remove_op;

    logic          r_in_vld;
    logic [7:0]    r_byte;

    logic [PW-1:0] r_pos;
    logic [31:0]   r_crc,    n_crc;
    logic [127:0]  r_hdr,    n_hdr;
    logic [31:0]   r_stored, n_stored;
    logic [31:0]   r_commit, n_commit;
    logic          r_fname,  n_fname;
    logic          r_fpad,   n_fpad;

    logic          r_out_vld;
    t_verdict      r_out;

    logic          w_last;
    logic          w_adv;
    logic [31:0]   w_p;
    logic [15:0]   w_nl;
    logic [15:0]   w_cl;
    t_sector       w_sector;
    t_verdict      w_verdict;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_op  <= WRITE_OP_RESET;
            r_remove_op <= REMOVE_OP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WRITE_OP:  r_write_op  <= i_cfg_wdata;
                CFG_REMOVE_OP: r_remove_op <= i_cfg_wdata;
                default:       r_write_op  <= r_write_op;
            endcase
        end
    end

    // input register
    assign w_last        = (r_pos == POS_LAST);
    assign w_adv         = r_in_vld && (!w_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

    // per-byte checks
    assign w_p  = 32'(r_pos);
    assign w_nl = r_hdr[111:96];
    assign w_cl = r_hdr[127:112];

    always_comb begin
        n_crc    = r_crc;
        n_hdr    = r_hdr;
        n_stored = r_stored;
        n_commit = r_commit;
        n_fname  = r_fname;
        n_fpad   = r_fpad;
        if (w_p < CRC_HDR_BYTES) begin
            n_hdr[{r_pos[3:0], 3'b000} +: 8] = r_byte;
            n_crc = crc_byte(r_crc, r_byte);
        end else if (w_p < HDR_BYTES) begin
            n_stored[{r_pos[1:0], 3'b000} +: 8] = r_byte;
        end else if (w_p < CONTENT_START) begin
            if ((w_p - HDR_BYTES) < 32'(w_nl)) begin
                if (r_byte < 8'h21 || r_byte == 8'h2F || r_byte == 8'h5C) begin
                    n_fname = 1'b1;
                end
            end else if (r_byte != 8'd0) begin
                n_fpad = 1'b1;
            end
            n_crc = crc_byte(r_crc, r_byte);
        end else if (w_p < PAYLOAD_END) begin
            if ((w_p - CONTENT_START) >= 32'(w_cl) && r_byte != 8'd0) begin
                n_fpad = 1'b1;
            end
            n_crc = crc_byte(r_crc, r_byte);
        end else if (w_p < COMMIT_START && r_byte != 8'd0) begin
            n_fpad = 1'b1;
        end
        if (w_p >= COMMIT_START) begin
            n_commit[{2'(w_p - COMMIT_START), 3'b000} +: 8] = r_byte;
        end
    end

    always_comb begin
        w_sector.magic       = n_hdr[31:0];
        w_sector.version     = n_hdr[47:32];
        w_sector.op          = n_hdr[63:48];
        w_sector.seq         = n_hdr[95:64];
        w_sector.name_len    = n_hdr[111:96];
        w_sector.content_len = n_hdr[127:112];
        w_sector.commit      = n_commit;
        w_sector.crc         = n_crc;
        w_sector.stored_crc  = n_stored;
        w_sector.flag_name   = n_fname;
        w_sector.flag_pad    = n_fpad;
    end

    jrc_verdict #(
        .NAME_BYTES    (NAME_BYTES),
        .CONTENT_BYTES (CONTENT_BYTES)
    ) u_verdict (
        .i_sector    (w_sector),
        .i_write_op  (r_write_op),
        .i_remove_op (r_remove_op),
        .o_verdict   (w_verdict)
    );

    // sector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_hdr    <= '0;
            r_stored <= '0;
            r_commit <= '0;
            r_fname  <= 1'b0;
            r_fpad   <= 1'b0;
        end else if (w_adv) begin
            if (w_last) begin
                r_pos    <= '0;
                r_crc    <= CRC_INIT;
                r_hdr    <= '0;
                r_stored <= '0;
                r_commit <= '0;
                r_fname  <= 1'b0;
                r_fpad   <= 1'b0;
            end else begin
                r_pos    <= r_pos + 1'b1;
                r_crc    <= n_crc;
                r_hdr    <= n_hdr;
                r_stored <= n_stored;
                r_commit <= n_commit;
                r_fname  <= n_fname;
                r_fpad   <= n_fpad;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv && w_last) begin
            r_out <= w_verdict;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out.content_len, r_out.name_len, r_out.seq,
                            r_out.op, r_out.reason, r_out.record_valid};

    // checks
    a_verdict_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_adv && w_last))
        else $error("verdict request without a last sector byte");

    a_valid_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[4:1] == REASON_OK)))
        else $error("record_valid disagrees with fail_reason");

    a_pos_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last) |=> (r_pos == '0 && r_crc == CRC_INIT && !r_fpad))
        else $error("sector state not cleared after verdict");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && w_last && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while last byte blocked by waiting verdict");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for journal_record_checker: streams whole sectors in, checks each verdict.
// Depends on jrc_pkg and the journal_record_checker RTL; sectors are built and predicted here.
`timescale 1ns / 100ps

module tb_top;
    import jrc_pkg::*;

    localparam int unsigned CONTENT_START = HDR_BYTES + NAME_BYTES_DEF;
    localparam int unsigned PAYLOAD_END   = CONTENT_START + CONTENT_BYTES_DEF;
    localparam int unsigned COMMIT_START  = SECTOR_BYTES_DEF - COMMIT_BYTES;
    localparam logic [7:0]  SLASH_CH      = 8'h2F;
    localparam logic [7:0]  BSLASH_CH     = 8'h5C;
    localparam logic [7:0]  FIRST_PRINT   = 8'h21;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          HOLD_CYCLES   = 1500;

    typedef struct packed {
        logic        valid;
        t_reason     reason;
        logic [15:0] op;
        logic [31:0] seq;
        logic [4:0]  name_len;
        logic [8:0]  content_len;
    } t_tb_verdict;

    typedef enum int {
        S_GOOD_WRITE, S_GOOD_REMOVE, S_MAGIC, S_VERSION, S_ZERO_SEQ, S_COMMIT, S_OP,
        S_NAME_ZERO, S_NAME_LONG, S_NAME_CTRL, S_NAME_SLASH, S_NAME_BSLASH, S_LEN,
        S_RM_DATA, S_CRC, S_NAME_PAD, S_CONTENT_PAD, S_TAIL_PAD, S_NOISE
    } t_sector_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_WRITE_OP;
    logic [15:0] i_cfg_wdata = '0;

    always #1 i_clk = ~i_clk;

    journal_record_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // pending sector bytes and verdicts still owed by the block
    logic [7:0]  byte_q[$];
    t_tb_verdict verdicts_due[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_tickets = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int sectors_checked = 0;
    int valid_seen = 0;
    logic [10:0] reasons_hit = '0;

    // generator's view of the operation codes
    logic [15:0] gen_wr = WRITE_OP_RESET;
    logic [15:0] gen_rm = REMOVE_OP_RESET;

    // predictor state
    int unsigned  sec_pos;
    logic [31:0]  run_crc;
    logic [127:0] hdr_acc;
    logic [31:0]  stored_crc;
    logic [31:0]  commit_acc;
    logic         name_bad;
    logic         pad_bad;
    logic [15:0]  cfg_wr;
    logic [15:0]  cfg_rm;

    function automatic logic [31:0] crc_shift(logic [31:0] c, logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_sector_state();
        sec_pos    = 0;
        run_crc    = CRC_INIT;
        hdr_acc    = '0;
        stored_crc = '0;
        commit_acc = '0;
        name_bad   = 1'b0;
        pad_bad    = 1'b0;
    endtask

    task automatic track_sector_byte(input logic [7:0] b);
        logic [15:0] nl;
        logic [15:0] cl;
        logic [15:0] op;
        logic [31:0] seq;
        logic        name_ok;
        logic        len_ok;
        t_reason     why;
        t_tb_verdict v;
        nl = hdr_acc[111:96];
        cl = hdr_acc[127:112];
        if (sec_pos < CRC_HDR_BYTES) begin
            hdr_acc[8*sec_pos +: 8] = b;
            run_crc = crc_shift(run_crc, b);
        end else if (sec_pos < HDR_BYTES) begin
            stored_crc[8*(sec_pos-CRC_HDR_BYTES) +: 8] = b;
        end else if (sec_pos < CONTENT_START) begin
            if (sec_pos - HDR_BYTES < nl) begin
                if (b < FIRST_PRINT || b == SLASH_CH || b == BSLASH_CH) name_bad = 1'b1;
            end else if (b != 0) begin
                pad_bad = 1'b1;
            end
            run_crc = crc_shift(run_crc, b);
        end else if (sec_pos < PAYLOAD_END) begin
            if (sec_pos - CONTENT_START >= cl && b != 0) pad_bad = 1'b1;
            run_crc = crc_shift(run_crc, b);
        end else if (sec_pos < COMMIT_START && b != 0) begin
            pad_bad = 1'b1;
        end
        if (sec_pos >= COMMIT_START) commit_acc[8*(sec_pos-COMMIT_START) +: 8] = b;
        if (sec_pos + 1 < SECTOR_BYTES_DEF) begin
            sec_pos++;
            return;
        end
        op      = hdr_acc[63:48];
        seq     = hdr_acc[95:64];
        name_ok = nl != 0 && nl < NAME_BYTES_DEF && !name_bad;
        len_ok  = cl <= CONTENT_BYTES_DEF;
        if (hdr_acc[31:0] != MAGIC_WORD)              why = REASON_MAGIC;
        else if (hdr_acc[47:32] != VERSION_WORD)      why = REASON_VERSION;
        else if (seq == 0)                            why = REASON_ZERO_SEQ;
        else if (commit_acc != COMMIT_MARK)           why = REASON_COMMIT;
        else if (op != cfg_wr && op != cfg_rm)        why = REASON_OP;
        else if (!name_ok)                            why = REASON_NAME;
        else if (!len_ok)                             why = REASON_LENGTH;
        else if (op == cfg_rm && cl != 0)             why = REASON_REMOVE_DATA;
        else if (~run_crc != stored_crc)              why = REASON_CRC;
        else if (pad_bad)                             why = REASON_PADDING;
        else                                          why = REASON_OK;
        v.valid       = why == REASON_OK;
        v.reason      = why;
        v.op          = op;
        v.seq         = seq;
        v.name_len    = name_ok ? nl[4:0] : 5'd0;
        v.content_len = len_ok ? cl[8:0] : 9'd0;
        verdicts_due.push_back(v);
        clear_sector_state();
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request from the sequence
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_tickets) begin
            hold_seen <= hold_tickets;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= snk_stall_pct;
        end
    end

    // predictor and verdict check
    always @(posedge i_clk) begin
        t_tb_verdict exp_v;
        if (!i_rst_n) begin
            clear_sector_state();
            cfg_wr = WRITE_OP_RESET;
            cfg_rm = REMOVE_OP_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WRITE_OP) cfg_wr = i_cfg_wdata;
                else                           cfg_rm = i_cfg_wdata;
            end
            if (s_tvalid && s_tready) track_sector_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict 0x%0h with no sector pending", m_tdata);
                    errors++;
                end else begin
                    exp_v = verdicts_due.pop_front();
                    compare_field("record_valid", 32'(exp_v.valid), 32'(m_tdata[0]));
                    compare_field("fail_reason", 32'(exp_v.reason), 32'(m_tdata[4:1]));
                    compare_field("operation", 32'(exp_v.op), 32'(m_tdata[20:5]));
                    compare_field("sequence_number", exp_v.seq, m_tdata[52:21]);
                    compare_field("name_len", 32'(exp_v.name_len), 32'(m_tdata[57:53]));
                    compare_field("content_len", 32'(exp_v.content_len),
                                  32'(m_tdata[66:58]));
                    sectors_checked++;
                    if (exp_v.valid) valid_seen++;
                    reasons_hit[exp_v.reason] = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("journal_record_checker test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // builds one sector, well formed apart from the fault that kind selects
    task automatic make_sector(input t_sector_kind kind, input logic [15:0] op_in,
                               input logic [31:0] seq_in, input int nl_in, input int cl_in);
        logic [7:0]   s [SECTOR_BYTES_DEF];
        logic [15:0]  op;
        logic [15:0]  ver;
        logic [15:0]  nl;
        logic [15:0]  cl;
        logic [31:0]  seq;
        logic [31:0]  crc;
        logic [127:0] hdr;
        logic [7:0]   nb;
        op  = op_in;
        seq = seq_in;
        nl  = 16'(nl_in);
        cl  = 16'(cl_in);
        ver = VERSION_WORD;
        case (kind)
            S_VERSION: begin
                ver = 16'($urandom);
                if (ver == VERSION_WORD) ver = 16'h8001;
            end
            S_ZERO_SEQ:    seq = '0;
            S_OP:          while (op == gen_wr || op == gen_rm) op = 16'($urandom);
            S_NAME_ZERO:   nl = '0;
            S_NAME_LONG: begin
                if (nl < NAME_BYTES_DEF) nl = 16'($urandom_range(NAME_BYTES_DEF, 65535));
            end
            S_LEN: begin
                if (cl <= CONTENT_BYTES_DEF) cl = 16'($urandom_range(CONTENT_BYTES_DEF + 1, 65535));
            end
            S_RM_DATA: begin
                op = gen_rm;
                if (cl == 0) cl = 16'($urandom_range(1, CONTENT_BYTES_DEF));
            end
            S_CONTENT_PAD: begin
                if (cl >= CONTENT_BYTES_DEF) cl = 16'($urandom_range(0, CONTENT_BYTES_DEF - 1));
            end
            default: ;
        endcase
        hdr = {cl, nl, seq, op, ver, MAGIC_WORD};
        for (int k = 0; k < SECTOR_BYTES_DEF; k++) s[k] = '0;
        for (int k = 0; k < CRC_HDR_BYTES; k++) s[k] = hdr[8*k +: 8];
        for (int k = 0; k < NAME_BYTES_DEF; k++) begin
            if (k < nl) begin
                nb = 8'($urandom_range(FIRST_PRINT, 255));
                while (nb == SLASH_CH || nb == BSLASH_CH) nb = 8'($urandom_range(FIRST_PRINT, 255));
                s[HDR_BYTES + k] = nb;
            end
        end
        for (int k = 0; k < CONTENT_BYTES_DEF; k++) begin
            if (k < cl) s[CONTENT_START + k] = 8'($urandom);
        end
        for (int k = 0; k < COMMIT_BYTES; k++) s[COMMIT_START + k] = COMMIT_MARK[8*k +: 8];
        case (kind)
            S_MAGIC:  s[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            S_COMMIT: s[COMMIT_START + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            S_NAME_CTRL: begin
                s[HDR_BYTES + $urandom_range(0, nl - 1)] = 8'($urandom_range(0, FIRST_PRINT - 1));
            end
            S_NAME_SLASH:  s[HDR_BYTES + $urandom_range(0, nl - 1)] = SLASH_CH;
            S_NAME_BSLASH: s[HDR_BYTES + $urandom_range(0, nl - 1)] = BSLASH_CH;
            S_NAME_PAD: begin
                s[HDR_BYTES + $urandom_range(nl, NAME_BYTES_DEF - 1)] = 8'($urandom_range(1, 255));
            end
            S_CONTENT_PAD: begin
                s[CONTENT_START + $urandom_range(cl, CONTENT_BYTES_DEF - 1)] =
                    8'($urandom_range(1, 255));
            end
            S_TAIL_PAD: begin
                s[$urandom_range(PAYLOAD_END, COMMIT_START - 1)] = 8'($urandom_range(1, 255));
            end
            S_NOISE:       for (int k = 0; k < SECTOR_BYTES_DEF; k++) s[k] = 8'($urandom);
            default: ;
        endcase
        crc = CRC_INIT;
        for (int k = 0; k < CRC_HDR_BYTES; k++) crc = crc_shift(crc, s[k]);
        for (int k = HDR_BYTES; k < PAYLOAD_END; k++) crc = crc_shift(crc, s[k]);
        crc = ~crc;
        if (kind == S_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
        if (kind != S_NOISE) begin
            for (int k = 0; k < 4; k++) s[CRC_HDR_BYTES + k] = crc[8*k +: 8];
        end
        for (int k = 0; k < SECTOR_BYTES_DEF; k++) byte_q.push_back(s[k]);
    endtask

    // mostly well-formed records, the rest single faults and noise
    task automatic random_sector();
        t_sector_kind kind;
        logic [15:0]  op;
        logic [31:0]  seq;
        int           r;
        int           cl;
        r = $urandom_range(0, 99);
        if (r < 35)      kind = S_GOOD_WRITE;
        else if (r < 55) kind = S_GOOD_REMOVE;
        else             kind = t_sector_kind'($urandom_range(S_MAGIC, S_NOISE));
        op  = (kind == S_GOOD_REMOVE) ? gen_rm : gen_wr;
        seq = $urandom;
        if (seq == 0) seq = 32'hFFFF_FFFF;
        cl  = (op == gen_rm) ? 0 : $urandom_range(0, CONTENT_BYTES_DEF);
        make_sector(kind, op, seq, $urandom_range(1, NAME_BYTES_DEF - 1), cl);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (byte_q.size() != 0 || s_tvalid || verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_codes(input logic [15:0] wr, input logic [15:0] rm);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_WRITE_OP;
        i_cfg_wdata <= wr;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_REMOVE_OP;
        i_cfg_wdata <= rm;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_wr = wr;
        gen_rm = rm;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int src, input int snk, input int count);
        src_idle_pct  = src;
        snk_stall_pct = snk;
        for (int n = 0; n < count; n++) random_sector();
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes and every failing check, reset codes, no idling
        make_sector(S_GOOD_WRITE, gen_wr, 32'hFFFF_FFFF, NAME_BYTES_DEF - 1, CONTENT_BYTES_DEF);
        make_sector(S_GOOD_WRITE, gen_wr, 32'd1, 1, 0);
        make_sector(S_GOOD_REMOVE, gen_rm, 32'h8000_0000, 5, 0);
        make_sector(S_MAGIC, gen_wr, 32'd7, 4, 10);
        make_sector(S_VERSION, gen_wr, 32'd7, 4, 10);
        make_sector(S_ZERO_SEQ, gen_wr, 32'd7, 4, 10);
        make_sector(S_COMMIT, gen_wr, 32'd7, 4, 10);
        make_sector(S_OP, gen_wr, 32'd7, 4, 10);
        make_sector(S_NAME_ZERO, gen_wr, 32'd7, 4, 10);
        make_sector(S_NAME_LONG, gen_wr, 32'd7, NAME_BYTES_DEF, 10);
        make_sector(S_NAME_LONG, gen_wr, 32'd7, 65535, 10);
        make_sector(S_NAME_CTRL, gen_wr, 32'd7, 8, 10);
        make_sector(S_NAME_SLASH, gen_wr, 32'd7, 8, 10);
        make_sector(S_NAME_BSLASH, gen_wr, 32'd7, 8, 10);
        make_sector(S_LEN, gen_wr, 32'd7, 4, CONTENT_BYTES_DEF + 1);
        make_sector(S_LEN, gen_wr, 32'd7, 4, 65535);
        make_sector(S_RM_DATA, gen_rm, 32'd7, 4, CONTENT_BYTES_DEF);
        make_sector(S_CRC, gen_wr, 32'd7, 4, 10);
        make_sector(S_NAME_PAD, gen_wr, 32'd7, 4, 10);
        make_sector(S_CONTENT_PAD, gen_wr, 32'd7, 4, 10);
        make_sector(S_TAIL_PAD, gen_wr, 32'd7, 4, 10);
        make_sector(S_NOISE, gen_wr, 32'd7, 4, 10);
        drain();

        set_codes(16'h0000, 16'hFFFF);
        random_phase(58, 0, 12);
        set_codes(16'hFFFF, 16'h0000);
        random_phase(0, 58, 12);
        // both codes equal: that code is treated as remove
        set_codes(16'h5A5A, 16'h5A5A);
        random_phase(29, 29, 10);

        // receiver holds off while the sender keeps offering bytes
        set_codes(16'($urandom), 16'($urandom));
        hold_tickets++;
        random_phase(0, 0, 12);

        $display("Covered %0d sectors over five code settings, %0d valid;", sectors_checked,
                 valid_seen);
        $display("%0d of 11 verdict reasons seen, with idling, stalls and a long hold-off.",
                 $countones(reasons_hit));
        if (errors == 0) begin
            $display("journal_record_checker test passed");
        end else begin
            $display("journal_record_checker test failed");
        end
        $finish;
    end

endmodule
